FILE: sv/ijh_pkg.sv
package ijh_pkg;

    // Field widths of the sample and result items.
    localparam int ACC_W   = 16;
    localparam int MS_W    = 32;
    localparam int MAG_W   = 20;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Shared multiplier operand and product widths (signed).
    localparam int MA_W    = ACC_W + 1;
    localparam int MB_W    = MS_W + 1;
    localparam int MP_W    = MA_W + MB_W;

    // Sum of squares, square-root radicand and threshold product widths.
    localparam int SUM_W   = 32;
    localparam int RAD_W   = SUM_W + 8;
    localparam int NEED_W  = CFG_W + MS_W;
    localparam int CMP_W   = NEED_W + 4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HOLDOFF     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_START_MARK  = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] SENS_RESET    = 16'd600;
    localparam logic [CFG_W-1:0] HOLDOFF_RESET = 16'd50;

    // Control into and status out of the square-root unit.
    typedef struct packed {
        logic start;
    } t_sqrt_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_sts;

endpackage

FILE: sv/ijh_mul.sv
module ijh_mul (
    input  logic                                i_clk,
    input  logic signed [ijh_pkg::MA_W-1:0]     i_a,
    input  logic signed [ijh_pkg::MB_W-1:0]     i_b,
    output logic signed [ijh_pkg::MP_W-1:0]     o_p
);
    import ijh_pkg::*;

    logic signed [MP_W-1:0] r_p;

    // Registered signed multiply, shared by the squares and the threshold.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: sv/ijh_sqrt.sv
module ijh_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ijh_pkg::t_sqrt_ctl            i_ctl,
    input  logic [ijh_pkg::RAD_W-1:0]     i_rad,
    output ijh_pkg::t_sqrt_sts            o_sts,
    output logic [ijh_pkg::MAG_W-1:0]     o_root
);
    import ijh_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);
    localparam int REM_W = MAG_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SH_W-1:0]  w_shift;
    logic [SH_W-1:0]  w_trial;
    logic [SH_W-1:0]  w_diff;
    logic             w_ge;

    // One root bit per cycle: bring down two radicand bits and try 4*root+1.
    always_comb begin
        w_shift = {r_rem, r_rad[RAD_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (w_shift >= w_trial);
        w_diff  = w_shift - w_trial;
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and radicand shift register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
            r_root <= {r_root[MAG_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

FILE: sv/impact_jerk_hit_detector.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// sample in | in        | i_in_valid / o_in_stall    | accel_x, accel_y, accel_z, sample_ms
// result    | out       | o_out_valid / i_out_stall  | hit, elapsed_ms, led_phase, magnitude_q4
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item goes from acceptance through the shared multiplier (three squares and the threshold
// product), twenty iterations of the square-root unit, then completion, compare and update,
// to its result in the output register. The next item is accepted only once that result has
// been loaded into the output register and the sequencer is back in idle.
// o_in_stall is high while an item is being worked on, and the result waits in the output
// register while i_out_stall is high. Reset is synchronous and restores register defaults.
module impact_jerk_hit_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ijh_pkg::ACC_W-1:0]    i_accel_x,
    input  logic signed [ijh_pkg::ACC_W-1:0]    i_accel_y,
    input  logic signed [ijh_pkg::ACC_W-1:0]    i_accel_z,
    input  logic        [ijh_pkg::MS_W-1:0]     i_sample_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic signed [ijh_pkg::MS_W-1:0]     o_elapsed_ms,
    output logic                                o_led_phase,
    output logic        [ijh_pkg::MAG_W-1:0]    o_magnitude_q4,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [ijh_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic        [ijh_pkg::MS_W-1:0]     i_cfg_data
);
    import ijh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [2:0] STEP_X    = 3'd0;
    localparam logic [2:0] STEP_Y    = 3'd1;
    localparam logic [2:0] STEP_Z    = 3'd2;
    localparam logic [2:0] STEP_NEED = 3'd3;
    localparam logic [2:0] STEP_LAST = 3'd4;

    // Configuration registers.
    logic [CFG_W-1:0]        r_sens;
    logic [CFG_W-1:0]        r_holdoff;
    logic [MS_W-1:0]         r_start;

    // Detector state carried from item to item.
    logic [MS_W-1:0]         r_last_sample_ms;
    logic [MAG_W-1:0]        r_last_mag;
    logic [MS_W-1:0]         r_last_hit_ms;
    logic                    r_led;

    // Sequencer and working registers.
    logic [2:0]              r_state;
    logic [2:0]              r_step;
    logic signed [ACC_W-1:0] r_x;
    logic signed [ACC_W-1:0] r_y;
    logic signed [ACC_W-1:0] r_z;
    logic [MS_W-1:0]         r_ms;
    logic [SUM_W-1:0]        r_sum;
    logic [NEED_W-1:0]       r_need;
    logic                    r_hit;

    // Output register.
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [MS_W-1:0]         r_out_elapsed;
    logic                    r_out_led;
    logic [MAG_W-1:0]        r_out_mag;

    logic signed [MA_W-1:0]  w_ma;
    logic signed [MB_W-1:0]  w_mb;
    logic signed [MP_W-1:0]  w_prod;
    logic [MS_W-1:0]         w_dt;
    logic [MS_W-1:0]         w_since_hit;
    logic [MAG_W-1:0]        w_mag;
    logic [MAG_W-1:0]        w_rise;
    logic                    w_rise_ok;
    logic                    w_accept;
    logic                    w_load_out;
    t_sqrt_ctl               w_sqrt_ctl;
    t_sqrt_sts               w_sqrt_sts;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_dt        = r_ms - r_last_sample_ms;
    assign w_since_hit = r_ms - r_last_hit_ms;
    assign w_load_out  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens    <= SENS_RESET;
            r_holdoff <= HOLDOFF_RESET;
            r_start   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SENSITIVITY: r_sens    <= i_cfg_data[CFG_W-1:0];
                CFG_HOLDOFF:     r_holdoff <= i_cfg_data[CFG_W-1:0];
                CFG_START_MARK:  r_start   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplier operands: the three squares, then sensitivity times elapsed time.
    always_comb begin
        case (r_step)
            STEP_X: begin
                w_ma = MA_W'(r_x);
                w_mb = MB_W'(r_x);
            end
            STEP_Y: begin
                w_ma = MA_W'(r_y);
                w_mb = MB_W'(r_y);
            end
            STEP_Z: begin
                w_ma = MA_W'(r_z);
                w_mb = MB_W'(r_z);
            end
            default: begin
                w_ma = {1'b0, r_sens};
                w_mb = {1'b0, w_dt};
            end
        endcase
    end

    ijh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // The square root starts once the sum of squares is complete.
    assign w_sqrt_ctl.start = (r_state == S_MUL) && (r_step == STEP_LAST);

    ijh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sqrt_ctl),
        .i_rad   ({r_sum, 8'd0}),
        .o_sts   (w_sqrt_sts),
        .o_root  (w_mag)
    );

    // Rise of the magnitude; a falling magnitude never meets the threshold.
    assign w_rise    = w_mag - r_last_mag;
    assign w_rise_ok = (w_mag >= r_last_mag)
                       && ({(CMP_W - MAG_W)'(0), w_rise} >= {r_need, 4'd0});

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_X;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                        r_step  <= STEP_X;
                    end
                end
                S_MUL: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_sts.done) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Sample capture, accumulation of squares and the threshold product.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= i_accel_x;
            r_y   <= i_accel_y;
            r_z   <= i_accel_z;
            r_ms  <= i_sample_ms;
            r_sum <= '0;
        end else if (r_state == S_MUL) begin
            if (r_step == STEP_LAST) begin
                r_need <= w_prod[NEED_W-1:0];
            end else if (r_step != STEP_X) begin
                r_sum <= r_sum + w_prod[SUM_W-1:0];
            end
        end
    end

    // Hit decision: nonzero elapsed time, enough rise and hold-off passed.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_hit <= (w_dt != '0) && w_rise_ok
                     && (w_since_hit >= {(MS_W - CFG_W)'(0), r_holdoff});
        end
    end

    // Detector state update when the result goes to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample_ms <= '0;
            r_last_mag       <= '0;
            r_last_hit_ms    <= '0;
            r_led            <= 1'b1;
        end else if (w_load_out) begin
            r_last_sample_ms <= r_ms;
            r_last_mag       <= w_mag;
            r_led            <= r_led ^ r_hit;
            if (r_hit) begin
                r_last_hit_ms <= r_ms;
            end
        end
    end

    // Output register holds the result item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_hit     <= r_hit;
            r_out_elapsed <= r_hit ? (r_ms - r_start) : '0;
            r_out_led     <= r_led ^ r_hit;
            r_out_mag     <= w_mag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_elapsed_ms   = r_out_elapsed;
    assign o_led_phase    = r_out_led;
    assign o_magnitude_q4 = r_out_mag;

    // The square-root unit finishes only while the sequencer waits for it.
    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_sts.done |-> (r_state == S_SQRT))
        else $error("square-root completion outside its wait state");

    // An accepted item always starts with the first square.
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MUL) && (r_step == STEP_X))
        else $error("accepted item did not start the multiply sequence");

    // A result that is no hit reports zero elapsed time.
    a_elapsed_zero_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_elapsed_ms == '0))
        else $error("elapsed time reported without a hit");

    // The square-root unit is never restarted while it is still iterating.
    a_sqrt_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_ctl.start |-> !w_sqrt_sts.busy)
        else $error("square-root unit restarted while busy");

endmodule

FILE: verif/testbench.sv
module testbench;

    import ijh_pkg::*;

    // Index outside the register map; writes to it must change nothing.
    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 215;

    typedef enum {QUIET, SPIKE, ANY, CORNER} accel_style_t;

    typedef struct {
        logic              hit;
        logic [MS_W-1:0]   elapsed;
        logic              led;
        logic [MAG_W-1:0]  mag;
    } hit_report_t;

    // Keeps its own copy of the detector state and settings, and the reports still due.
    class hit_scoreboard;
        logic [CFG_W-1:0] sensitivity;
        logic [CFG_W-1:0] holdoff;
        logic [MS_W-1:0]  start_mark;
        logic [MS_W-1:0]  prev_ms;
        logic [MAG_W-1:0] prev_mag;
        logic [MS_W-1:0]  last_hit_ms;
        logic             led;
        hit_report_t      reports_due[$];
        int               mismatches;

        function new();
            sensitivity = SENS_RESET;
            holdoff     = HOLDOFF_RESET;
            start_mark  = '0;
            prev_ms     = '0;
            prev_mag    = '0;
            last_hit_ms = '0;
            led         = 1'b1;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [MS_W-1:0] data);
            case (idx)
                CFG_SENSITIVITY: begin
                    sensitivity = data[CFG_W-1:0];
                end
                CFG_HOLDOFF: begin
                    holdoff = data[CFG_W-1:0];
                end
                CFG_START_MARK: begin
                    start_mark = data;
                end
                default: begin
                end
            endcase
        endfunction

        function int outstanding();
            return reports_due.size();
        endfunction

        // Works out the report for one accepted sample and advances the state.
        function void note_sample(logic signed [ACC_W-1:0] ax, logic signed [ACC_W-1:0] ay,
                                  logic signed [ACC_W-1:0] az, logic [MS_W-1:0] ms);
            int               xi;
            int               yi;
            int               zi;
            longint unsigned  radicand;
            logic [MAG_W-1:0] mag;
            logic [MAG_W-1:0] trial;
            logic [MS_W-1:0]  dt;
            logic [MS_W-1:0]  since;
            longint           rise;
            longint           need;
            hit_report_t      rep;
            xi = ax;
            yi = ay;
            zi = az;
            radicand = longint'(xi) * longint'(xi) + longint'(yi) * longint'(yi)
                     + longint'(zi) * longint'(zi);
            radicand = radicand << 8;
            // Exact floor square root, one result bit at a time from the top.
            mag = '0;
            for (int b = MAG_W - 1; b >= 0; b--) begin
                trial = mag | (20'd1 << b);
                if (longint'(trial) * longint'(trial) <= radicand) begin
                    mag = trial;
                end
            end
            dt    = ms - prev_ms;
            since = ms - last_hit_ms;
            rise  = longint'(mag) - longint'(prev_mag);
            need  = longint'(sensitivity) * 16 * longint'(dt);
            rep.hit = (dt != 0) && (rise >= need) && (since >= {16'd0, holdoff});
            prev_ms  = ms;
            prev_mag = mag;
            rep.elapsed = '0;
            if (rep.hit) begin
                led         = ~led;
                last_hit_ms = ms;
                rep.elapsed = ms - start_mark;
            end
            rep.led = led;
            rep.mag = mag;
            reports_due.push_back(rep);
        endfunction

        // Compares one accepted result item with the oldest report due.
        function void check_result(logic hit, logic [MS_W-1:0] elapsed, logic led_out,
                                   logic [MAG_W-1:0] mag);
            hit_report_t exp_rep;
            if (reports_due.size() == 0) begin
                $error("result item with no sample outstanding");
                mismatches++;
                return;
            end
            exp_rep = reports_due.pop_front();
            if (hit !== exp_rep.hit) begin
                $error("hit: expected %0d, got %0d", exp_rep.hit, hit);
                mismatches++;
            end
            if (elapsed !== exp_rep.elapsed) begin
                $error("elapsed_ms: expected %0d, got %0d",
                       $signed(exp_rep.elapsed), $signed(elapsed));
                mismatches++;
            end
            if (led_out !== exp_rep.led) begin
                $error("led_phase: expected %0d, got %0d", exp_rep.led, led_out);
                mismatches++;
            end
            if (mag !== exp_rep.mag) begin
                $error("magnitude_q4: expected %0d, got %0d", exp_rep.mag, mag);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [ACC_W-1:0]  i_accel_x = '0;
    logic signed [ACC_W-1:0]  i_accel_y = '0;
    logic signed [ACC_W-1:0]  i_accel_z = '0;
    logic        [MS_W-1:0]   i_sample_ms = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_hit;
    logic signed [MS_W-1:0]   o_elapsed_ms;
    logic                     o_led_phase;
    logic        [MAG_W-1:0]  o_magnitude_q4;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic        [CIDX_W-1:0] i_cfg_index = '0;
    logic        [MS_W-1:0]   i_cfg_data = '0;

    hit_scoreboard   board = new();
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              quiet_cycles = 0;
    logic [MS_W-1:0] clock_ms = '0;

    impact_jerk_hit_detector u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_sample_ms    (i_sample_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_elapsed_ms   (o_elapsed_ms),
        .o_led_phase    (o_led_phase),
        .o_magnitude_q4 (o_magnitude_q4),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls at random at the current phase's rate.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Result checking, and a watchdog on cycles in which no item of any channel moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_hit, o_elapsed_ms, o_led_phase, o_magnitude_q4);
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("impact_jerk_hit_detector test failed");
            $finish;
        end
    end

    // Offers one sample and holds it until accepted, then idles at random.
    task automatic send_sample(input logic signed [ACC_W-1:0] ax,
                               input logic signed [ACC_W-1:0] ay,
                               input logic signed [ACC_W-1:0] az,
                               input logic [MS_W-1:0] ms);
        i_in_valid  <= 1'b1;
        i_accel_x   <= ax;
        i_accel_y   <= ay;
        i_accel_z   <= az;
        i_sample_ms <= ms;
        clock_ms = ms;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(ax, ay, az, ms);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stops offering samples and waits until every report due has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Writes all three registers back to back, optionally followed by the spare index.
    task automatic program_regs(input logic [MS_W-1:0] sens, input logic [MS_W-1:0] hold,
                                input logic [MS_W-1:0] mark, input bit poke_spare);
        logic [CIDX_W-1:0] idx_list[4];
        logic [MS_W-1:0]   val_list[4];
        int                n;
        idx_list[0] = CFG_SENSITIVITY;
        val_list[0] = sens;
        idx_list[1] = CFG_HOLDOFF;
        val_list[1] = hold;
        idx_list[2] = CFG_START_MARK;
        val_list[2] = mark;
        idx_list[3] = CFG_SPARE;
        val_list[3] = $urandom;
        n = poke_spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.set_reg(idx_list[k], val_list[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ACC_W-1:0] pick_accel(accel_style_t style);
        int mag_counts;
        case (style)
            QUIET: begin
                mag_counts = $urandom_range(600);
                return 16'(mag_counts - 300);
            end
            SPIKE: begin
                mag_counts = $urandom_range(32767, 16000);
                return $urandom_range(1) ? 16'(mag_counts) : 16'(-mag_counts);
            end
            CORNER: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    initial begin
        int           dice;
        accel_style_t style;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings: zero time step on the first sample,
        // hold-off after reset, largest vectors, falling magnitude and timestamp wrap.
        send_sample(0, 0, 0, 0);
        send_sample(32767, 0, 0, 1);
        send_sample(0, 0, 0, 2);
        send_sample(-32768, -32768, -32768, 60);
        send_sample(0, 0, 0, 60);
        send_sample(-32768, -32768, -32768, 60);
        send_sample(1, -1, 1, 61);
        send_sample(32767, 32767, 32767, 62);
        send_sample(0, 0, 0, 32'hFFFF_FFF0);
        send_sample(20000, -20000, 0, 3);

        // Zero threshold and no hold-off: a flat magnitude hits, a falling one does not.
        drain();
        program_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_sample(20000, -20000, 0, 4);
        send_sample(100, 0, 0, 5);
        send_sample(100, 0, 0, 5);
        send_sample(100, 0, 0, 6);
        send_sample(-1, -1, -1, 7);

        // Largest threshold and hold-off: even the biggest rise cannot hit.
        drain();
        program_regs(32'h0000_FFFF, 32'h0000_FFFF, 32'h8000_0000, 1'b0);
        send_sample(0, 0, 0, 10);
        send_sample(-32768, -32768, -32768, 11);
        send_sample(-32768, 32767, -32768, 32'h7FFF_FFFF);

        // Random phases, each with its own settings and idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: program_regs(32'd600, 32'd50, 32'd0, 1'b0);
                1: program_regs(32'd0, 32'd0, $urandom, 1'b0);
                2: program_regs(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 1'b0);
                3: program_regs($urandom_range(2000, 100), $urandom_range(100), $urandom, 1'b0);
                4: program_regs(32'd1, 32'd1, 32'd0, 1'b0);
                5: program_regs($urandom, $urandom, $urandom, 1'b1);
                6: program_regs(32'd600, 32'd50, $urandom, 1'b1);
                default: program_regs($urandom_range(4000) | ($urandom << 16),
                                      $urandom_range(200), $urandom, 1'b0);
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 61;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 61;
                end
                default: begin
                    send_idle_pct = 28;
                    stall_pct = 28;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Once in the run the sender holds back until the block has emptied.
                if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
                    drain();
                end
                // Mostly short steady time steps; sometimes none, long gaps or jumps.
                dice = $urandom_range(99);
                if (dice < 6) begin
                    clock_ms = clock_ms;
                end else if (dice < 76) begin
                    clock_ms = clock_ms + $urandom_range(12, 1);
                end else if (dice < 88) begin
                    clock_ms = clock_ms + $urandom_range(120, 13);
                end else if (dice < 94) begin
                    clock_ms = clock_ms + $urandom;
                end else begin
                    clock_ms = $urandom;
                end
                // Quiet stretches broken by spikes make up most of the samples.
                dice = $urandom_range(99);
                if (dice < 55) begin
                    style = QUIET;
                end else if (dice < 80) begin
                    style = SPIKE;
                end else if (dice < 95) begin
                    style = ANY;
                end else begin
                    style = CORNER;
                end
                send_sample(pick_accel(style), pick_accel(style), pick_accel(style), clock_ms);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("impact_jerk_hit_detector test passed");
        end else begin
            $display("impact_jerk_hit_detector test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/ijh_pkg.sv
sv/ijh_mul.sv
sv/ijh_sqrt.sv
sv/impact_jerk_hit_detector.sv
verif/testbench.sv
